[rtl/core/mmsd_pkg.sv]
// Shared types and constants for the median/MAD spike detector.
package mmsd_pkg;

  localparam int VAL_W      = 48;
  localparam int WIN_DEPTH  = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = GAIN_W + VAL_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINLEN = 2'd2;

  localparam logic [CNT_W-1:0]  WARMUP_RST = 7'd5;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd768;
  localparam logic [CNT_W-1:0]  WINLEN_RST = 7'd32;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic we;
    idx_t addr;
    val_t data;
  } sel_ld_t;

  typedef struct packed {
    logic start;
    cnt_t n;
    cnt_t k;
  } sel_ctl_t;

endpackage

[rtl/core/mmsd_select.sv]
// Rank selection unit: scratch store and a single comparator swept over every pair.
module mmsd_select
  import mmsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sel_ld_t  ld,
  input  sel_ctl_t ctl,
  output logic     done,
  output val_t     result
);

  localparam logic [1:0] SL_IDLE  = 2'd0;
  localparam logic [1:0] SL_CAND  = 2'd1;
  localparam logic [1:0] SL_LATCH = 2'd2;
  localparam logic [1:0] SL_SWEEP = 2'd3;

  logic [1:0] state_r;
  val_t       mem [WIN_DEPTH];
  val_t       rdata_r;
  val_t       cand_r;
  val_t       result_r;
  idx_t       raddr;
  cnt_t       i_r;
  cnt_t       jn_r;
  cnt_t       lt_r;
  cnt_t       eq_r;
  cnt_t       n_r;
  cnt_t       k_r;
  cnt_t       lt_nxt;
  cnt_t       eq_nxt;
  logic       done_r;
  logic       hit;

  always_comb begin
    unique case (state_r)
      SL_CAND:  raddr = i_r[IDX_W-1:0];
      SL_SWEEP: raddr = jn_r[IDX_W-1:0];
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.we) begin
      mem[ld.addr] <= ld.data;
    end
    rdata_r <= mem[raddr];
  end

  assign lt_nxt = lt_r + CNT_W'(rdata_r < cand_r);
  assign eq_nxt = eq_r + CNT_W'(rdata_r == cand_r);
  assign hit    = (lt_nxt <= k_r) && (k_r < CNT_W'(lt_nxt + eq_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SL_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        SL_IDLE: begin
          if (ctl.start) begin
            n_r     <= ctl.n;
            k_r     <= ctl.k;
            i_r     <= '0;
            state_r <= SL_CAND;
          end
        end
        SL_CAND: begin
          state_r <= SL_LATCH;
        end
        SL_LATCH: begin
          cand_r  <= rdata_r;
          jn_r    <= CNT_W'(1);
          lt_r    <= '0;
          eq_r    <= '0;
          state_r <= SL_SWEEP;
        end
        SL_SWEEP: begin
          if (jn_r == n_r) begin
            if (hit || (i_r == CNT_W'(n_r - CNT_W'(1)))) begin
              result_r <= cand_r;
              done_r   <= 1'b1;
              state_r  <= SL_IDLE;
            end else begin
              i_r     <= i_r + CNT_W'(1);
              state_r <= SL_CAND;
            end
          end else begin
            jn_r <= jn_r + CNT_W'(1);
            lt_r <= lt_nxt;
            eq_r <= eq_nxt;
          end
        end
        default: state_r <= SL_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

[rtl/core/median_mad_spike_detector.sv]
// Median/MAD spike detector top level: registers, history store, sequencer and threshold.
// While the window is warming up the result skips rank selection; otherwise the time to a
// result is set by the rank selection unit, which compares one pair of entries per cycle
// for median and MAD.
// One transaction is in work at a time; the next is taken once the result is registered.
// Synchronous active-low reset clears the window and restores the register defaults.
module median_mad_spike_detector
  import mmsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VAL_W-1:0]      in_factor,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_spike,
  output logic [VAL_W-1:0]      out_window_median,
  output logic [VAL_W-1:0]      out_window_mad,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COPY = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_THR  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam int MUL_LO_W = 25;
  localparam int MUL_P_W  = GAIN_W + MUL_LO_W;

  logic [2:0]        state_r;
  cnt_t              warmup_r;
  logic [GAIN_W-1:0] gain_r;
  cnt_t              wlen_r;
  cnt_t              fill_r;
  idx_t              oldest_r;
  val_t              factor_r;
  val_t              median_r;
  val_t              mad_r;
  logic              spike_r;
  logic [PROD_W-1:0] prod_r;
  logic              thr_ph_r;
  logic              pass_r;
  cnt_t              cnt_r;
  logic              pend_r;
  idx_t              pend_idx_r;
  logic              start_r;
  val_t              hist_mem [WIN_DEPTH];
  val_t              hist_rd_r;
  logic              out_valid_r;
  logic              out_spike_r;
  val_t              out_median_r;
  val_t              out_mad_r;

  idx_t              hist_raddr;
  idx_t              hist_waddr;
  cnt_t              win_len;
  logic              active;
  logic              accept;
  logic              out_load;
  val_t              dev;
  logic [VAL_W:0]    mad_inc;
  logic [MUL_LO_W-1:0] mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [PROD_W-9:0] scaled;
  val_t              scaled_sat;
  logic [VAL_W:0]    thr_sum;
  val_t              thr;
  sel_ld_t           sel_ld;
  sel_ctl_t          sel_ctl;
  logic              sel_done;
  val_t              sel_result;

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign in_stall   = (state_r != ST_IDLE);
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign active     = (fill_r != '0) && (fill_r >= warmup_r);
  assign hist_raddr = oldest_r + cnt_r[IDX_W-1:0];
  assign hist_waddr = oldest_r + fill_r[IDX_W-1:0];

  always_comb begin
    priority if (wlen_r == '0) begin
      win_len = CNT_W'(1);
    end else if (wlen_r > CNT_W'(WIN_DEPTH)) begin
      win_len = CNT_W'(WIN_DEPTH);
    end else begin
      win_len = wlen_r;
    end
  end

  assign dev = (hist_rd_r >= median_r) ? (hist_rd_r - median_r) : (median_r - hist_rd_r);

  assign sel_ld.we   = (state_r == ST_COPY) && pend_r;
  assign sel_ld.addr = pend_idx_r;
  assign sel_ld.data = pass_r ? dev : hist_rd_r;

  assign sel_ctl.start = start_r;
  assign sel_ctl.n     = fill_r;
  assign sel_ctl.k     = fill_r >> 1;

  mmsd_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (sel_ld),
    .ctl    (sel_ctl),
    .done   (sel_done),
    .result (sel_result)
  );

  assign mad_inc    = {1'b0, mad_r} + (VAL_W+1)'(1);
  assign mul_b      = thr_ph_r ? {1'b0, mad_inc[VAL_W:MUL_LO_W]} : mad_inc[MUL_LO_W-1:0];
  assign mul_p      = {{MUL_LO_W{1'b0}}, gain_r} * {{GAIN_W{1'b0}}, mul_b};
  assign scaled     = prod_r[PROD_W-1:8];
  assign scaled_sat = (|scaled[PROD_W-9:VAL_W]) ? '1 : scaled[VAL_W-1:0];
  assign thr_sum    = {1'b0, median_r} + {1'b0, scaled_sat};
  assign thr        = thr_sum[VAL_W] ? '1 : thr_sum[VAL_W-1:0];

  always_ff @(posedge clk) begin
    hist_rd_r <= hist_mem[hist_raddr];
    if (state_r == ST_UPD) begin
      hist_mem[hist_waddr] <= factor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r <= WARMUP_RST;
      gain_r   <= GAIN_RST;
      wlen_r   <= WINLEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WARMUP: warmup_r <= cfg_wdata[CNT_W-1:0];
        CFG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_WINLEN: wlen_r   <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      oldest_r <= '0;
      pend_r   <= 1'b0;
      start_r  <= 1'b0;
      pass_r   <= 1'b0;
      thr_ph_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            factor_r <= in_factor;
            cnt_r    <= '0;
            pend_r   <= 1'b0;
            pass_r   <= 1'b0;
            if (active) begin
              state_r <= ST_COPY;
            end else begin
              median_r <= '0;
              mad_r    <= '0;
              spike_r  <= 1'b0;
              state_r  <= ST_UPD;
            end
          end
        end
        ST_COPY: begin
          if (cnt_r < fill_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= cnt_r[IDX_W-1:0];
            cnt_r      <= cnt_r + CNT_W'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              start_r <= 1'b1;
              state_r <= ST_SEL;
            end
          end
        end
        ST_SEL: begin
          start_r <= 1'b0;
          if (sel_done) begin
            if (!pass_r) begin
              median_r <= sel_result;
              pass_r   <= 1'b1;
              cnt_r    <= '0;
              pend_r   <= 1'b0;
              state_r  <= ST_COPY;
            end else begin
              mad_r   <= sel_result;
              state_r <= ST_THR;
            end
          end
        end
        ST_THR: begin
          if (!thr_ph_r) begin
            prod_r   <= PROD_W'(mul_p);
            thr_ph_r <= 1'b1;
          end else begin
            prod_r   <= prod_r + (PROD_W'(mul_p) << MUL_LO_W);
            thr_ph_r <= 1'b0;
            state_r  <= ST_CMP;
          end
        end
        ST_CMP: begin
          spike_r <= (factor_r > thr);
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (fill_r < CNT_W'(WIN_DEPTH)) begin
            if (fill_r >= win_len) begin
              oldest_r <= oldest_r + IDX_W'(1);
            end else begin
              fill_r <= fill_r + CNT_W'(1);
            end
          end else begin
            oldest_r <= oldest_r + IDX_W'(1);
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_spike_r  <= spike_r;
      out_median_r <= median_r;
      out_mad_r    <= mad_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_spike      = out_spike_r;
  assign out_window_median = out_median_r;
  assign out_window_mad    = out_mad_r;

endmodule

[rtl/core/mmsd_checker.sv]
// Port-level checker for the median/MAD spike detector and its bind statement.
module mmsd_checker
  import mmsd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_is_spike,
  input logic [VAL_W-1:0]      out_window_median,
  input logic [VAL_W-1:0]      out_window_mad
);

  // An accepted transaction keeps the input stalled until its result is registered.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_is_spike)
      && $stable(out_window_median) && $stable(out_window_mad)))
    else $error("stalled result changed or dropped");

  // A new result coincides with the block becoming free for the next transaction.
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while still busy");

  // A spike needs headroom above the median, so a saturated median never flags one.
  a_spike_headroom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_spike) |-> (out_window_median != {VAL_W{1'b1}}))
    else $error("spike flagged with saturated median");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind median_mad_spike_detector mmsd_checker u_mmsd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_is_spike      (out_is_spike),
  .out_window_median (out_window_median),
  .out_window_mad    (out_window_mad)
);
